[sv/wsd_pkg.sv]
// shared types and constants of the websocket frame deframer
`default_nettype none

package wsd_pkg;

  // width of the held payload length
  localparam int unsigned LENGTH_BITS = 64;
  // largest payload length that can be held, as a 64-bit value
  localparam logic [63:0] LEN_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - LENGTH_BITS);

  // second header byte fields
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  // extended length and key byte counts, minus one
  localparam logic [2:0] EXT16_LAST = 3'd1;
  localparam logic [2:0] EXT64_LAST = 3'd7;
  localparam logic [2:0] KEY_LAST   = 3'd3;

  // tuser width of the result side
  localparam int unsigned USER_W = 7;

  // one result transfer
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic [3:0] frame_opcode;
    logic       final_fragment;
    logic       was_masked;
    logic       end_of_frame;
  } result_t;

endpackage

`default_nettype wire

[sv/wsd_parser.sv]
// frame header parser and payload unmasking for one byte per cycle
`default_nettype none

module wsd_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             byte_valid_i,
  input  wire logic [7:0]       byte_i,
  output logic                  res_valid_o,
  output wsd_pkg::result_t      res_o
);

  typedef enum logic [2:0] {
    PH_HEAD1,
    PH_HEAD2,
    PH_EXTLEN,
    PH_KEY,
    PH_DATA
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        fin_q, fin_d;
  logic        mask_q, mask_d;
  logic [63:0] rem_q, rem_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  kpos_q, kpos_d;

  logic [63:0] len_sel;
  logic        len_known;
  logic [63:0] ext_nxt;
  logic [63:0] rem_dec;
  logic [7:0]  key_byte;
  logic        res_valid;
  wsd_pkg::result_t res;

  // key byte at the rotating position, first key byte in the top bits
  always_comb begin
    case (kpos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // extended length shift with saturation for a narrow length
  always_comb begin
    if ((wsd_pkg::LENGTH_BITS < 64) && (rem_q[63:56] != 8'd0)) begin
      ext_nxt = '1;
    end else begin
      ext_nxt = {rem_q[55:0], byte_i};
    end
  end

  assign rem_dec = rem_q - 64'd1;

  // next state and result
  always_comb begin
    phase_d   = phase_q;
    opcode_d  = opcode_q;
    fin_d     = fin_q;
    mask_d    = mask_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    key_d     = key_q;
    kpos_d    = kpos_q;
    len_sel   = rem_q;
    len_known = 1'b0;
    res_valid = 1'b0;
    res       = '0;

    case (phase_q)
      PH_HEAD2: begin
        mask_d = byte_i[7];
        key_d  = '0;
        if (byte_i[6:0] == wsd_pkg::LEN7_EXT16) begin
          rem_d   = '0;
          cnt_d   = wsd_pkg::EXT16_LAST;
          phase_d = PH_EXTLEN;
        end else if (byte_i[6:0] == wsd_pkg::LEN7_EXT64) begin
          rem_d   = '0;
          cnt_d   = wsd_pkg::EXT64_LAST;
          phase_d = PH_EXTLEN;
        end else begin
          len_sel   = {57'd0, byte_i[6:0]};
          len_known = 1'b1;
        end
      end
      PH_EXTLEN: begin
        if (cnt_q == 3'd0) begin
          len_sel   = (ext_nxt > wsd_pkg::LEN_MAX) ? wsd_pkg::LEN_MAX : ext_nxt;
          len_known = 1'b1;
        end else begin
          rem_d = ext_nxt;
          cnt_d = cnt_q - 3'd1;
        end
      end
      PH_KEY: begin
        key_d = {key_q[23:0], byte_i};
        if (cnt_q == 3'd0) begin
          kpos_d = '0;
          if (rem_q == 64'd0) begin
            phase_d            = PH_HEAD1;
            res_valid          = 1'b1;
            res.end_of_frame   = 1'b1;
          end else begin
            phase_d = PH_DATA;
          end
        end else begin
          cnt_d = cnt_q - 3'd1;
        end
      end
      PH_DATA: begin
        kpos_d           = kpos_q + 2'd1;
        rem_d            = rem_dec;
        res_valid        = 1'b1;
        res.data_byte    = byte_i ^ key_byte;
        res.has_data     = 1'b1;
        res.end_of_frame = (rem_dec == 64'd0);
        if (rem_dec == 64'd0) begin
          phase_d = PH_HEAD1;
        end
      end
      default: begin
        fin_d    = byte_i[7];
        opcode_d = byte_i[3:0];
        phase_d  = PH_HEAD2;
      end
    endcase

    // length complete: go on to the key or finish the header
    if (len_known) begin
      rem_d = len_sel;
      if (mask_d) begin
        phase_d = PH_KEY;
        cnt_d   = wsd_pkg::KEY_LAST;
      end else begin
        cnt_d  = '0;
        kpos_d = '0;
        if (len_sel == 64'd0) begin
          phase_d          = PH_HEAD1;
          res_valid        = 1'b1;
          res.end_of_frame = 1'b1;
        end else begin
          phase_d = PH_DATA;
        end
      end
    end

    res.frame_opcode   = opcode_d;
    res.final_fragment = fin_d;
    res.was_masked     = mask_d;
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEAD1;
      opcode_q <= '0;
      fin_q    <= 1'b0;
      mask_q   <= 1'b0;
      rem_q    <= '0;
      cnt_q    <= '0;
      key_q    <= '0;
      kpos_q   <= '0;
    end else if (byte_valid_i) begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      fin_q    <= fin_d;
      mask_q   <= mask_d;
      rem_q    <= rem_d;
      cnt_q    <= cnt_d;
      key_q    <= key_d;
      kpos_q   <= kpos_d;
    end
  end

  assign res_valid_o = byte_valid_i & res_valid;
  assign res_o       = res;

`ifndef SYNTHESIS
  // a payload phase never holds an empty remaining length
  a_data_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (rem_q != 64'd0))
    else $error("payload phase with zero remaining length");

  // the key position restarts at every new payload
  a_kpos_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) && ($past(phase_q) != PH_DATA) |-> (kpos_q == 2'd0))
    else $error("key position not restarted for payload");
`endif

endmodule

`default_nettype wire

[sv/websocket_frame_deframer.sv]
// websocket frame deframer top level with the result register
`default_nettype none

// Parses WebSocket (RFC 6455) frames from a byte stream and emits one
// transfer per unmasked payload byte, or one transfer without data at the
// end of a frame with an empty payload; header bytes emit nothing. One byte
// is taken per clock: the parser does all the work for a byte
// combinationally between its state registers and the result register,
// so the sustained rate is one byte per cycle as long as the result side
// takes its transfers. The result register lets a new byte in whenever it
// is empty or being emptied in the same cycle. Reserved header bits are
// ignored and every opcode is parsed alike.
module websocket_frame_deframer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  wire logic [7:0]                   s_axis_tdata_i,   // in_byte
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  output logic [7:0]                        m_axis_tdata_o,   // data_byte
  // has_data, frame_opcode[4:1], final_fragment, was_masked
  output logic [wsd_pkg::USER_W-1:0]        m_axis_tuser_o,
  output logic                              m_axis_tlast_o    // end_of_frame
);

  logic             in_xfer;
  logic             res_valid;
  wsd_pkg::result_t res;
  logic             out_valid_q;
  wsd_pkg::result_t out_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  wsd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(in_xfer),
    .byte_i      (s_axis_tdata_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && s_axis_tready_o) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.data_byte;
  assign m_axis_tuser_o  = {out_q.was_masked, out_q.final_fragment,
                            out_q.frame_opcode, out_q.has_data};
  assign m_axis_tlast_o  = out_q.end_of_frame;

`ifndef SYNTHESIS
  // a byte that yields a result shows it on the next cycle
  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> m_axis_tvalid_o)
    else $error("accepted result not presented");

  // an empty register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty result register");

  // a transfer without data is the end of an empty frame with zero data
  a_empty_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tlast_o && (m_axis_tdata_o == 8'd0))
    else $error("empty result is not a zero frame end");
`endif

endmodule

`default_nettype wire
